// ----- design/art_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// art_pkg: shared types, constants and tanh table for the activation unit
// Fixed-point geometry, register codes and the elaboration-time tanh ROM.
// ----------------------------------------------------------------------------
package art_pkg;

	// Data format: signed fixed point with FRAC_BITS fraction bits
	localparam int SAMPLE_W     = 16;
	localparam int FRAC_BITS    = 11;
	localparam int TANH_ENTRIES = 256;

	// Table entries lie in [0, ONE]
	localparam int ONE_W   = FRAC_BITS + 1;
	// Table span is [0, 4), i.e. 4 << FRAC_BITS in sample units
	localparam int SPAN_SH = FRAC_BITS + 2;
	localparam int IDX_W   = $clog2(TANH_ENTRIES);
	localparam int ROMA_W  = $clog2(TANH_ENTRIES + 1);
	localparam int P_W     = SAMPLE_W + ROMA_W;

	localparam logic [SAMPLE_W-1:0] ONE_Q   = SAMPLE_W'(1) << FRAC_BITS;
	localparam logic [ONE_W-1:0]    ONE_MAG = ONE_W'(1) << FRAC_BITS;

	// Configuration register indexes
	localparam logic [1:0] CFG_ACT_MODE   = 2'd0;
	localparam logic [1:0] CFG_DERIV_MODE = 2'd1;

	typedef enum logic [1:0] {
		ACT_RELU   = 2'd0,
		ACT_TANH   = 2'd1,
		ACT_LINEAR = 2'd2,
		ACT_NONE   = 2'd3
	} act_mode_t;

	// Sideband that travels next to the tanh datapath
	typedef struct packed {
		logic                       last;
		logic signed [SAMPLE_W-1:0] x;
	} side_t;

	typedef logic [ONE_W-1:0] tanh_rom_t [0:TANH_ENTRIES];

	// Shift-subtract divide, used only while building the table
	function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		int b;
		r = '0;
		q = '0;
		for (b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// tanh(4*i/N) via e^(-8i/N) = (1/e^(i/(2N)))^16, Q30 intermediates
	function automatic logic [ONE_W-1:0] rom_point(input int i);
		logic [63:0] z;
		logic [63:0] e;
		logic [63:0] term;
		logic [63:0] u;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] q30;
		logic [63:0] pt;
		int k;
		q30  = 64'd1 << 30;
		z    = udiv(64'(i) << 29, 64'(TANH_ENTRIES));
		e    = q30;
		term = q30;
		for (k = 1; k <= 24; k++) begin
			term = udiv((term * z) >> 30, 64'(k));
			e    = e + term;
		end
		u = udiv(64'd1 << 60, e);
		for (k = 0; k < 4; k++) begin
			u = (u * u) >> 30;
		end
		if (u > q30) begin
			u = q30;
		end
		num = q30 - u;
		den = q30 + u;
		pt  = udiv((num << (FRAC_BITS + 1)) + den, den << 1);
		return pt[ONE_W-1:0];
	endfunction

	function automatic tanh_rom_t build_rom();
		tanh_rom_t rom;
		int i;
		for (i = 0; i <= TANH_ENTRIES; i++) begin
			rom[i] = rom_point(i);
		end
		return rom;
	endfunction

	localparam tanh_rom_t TANH_ROM = build_rom();

endpackage
`default_nettype wire

// ----- design/art_tanh_mag.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// art_tanh_mag: three-stage tanh magnitude pipeline
// Takes |x| apart into table index and fraction, reads two neighboring table
// points, and interpolates between them. Saturates to one past the table.
// ----------------------------------------------------------------------------
module art_tanh_mag import art_pkg::*; (
	input  wire logic                       clk,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	output      logic        [ONE_W-1:0]    mag_s3
);

	// stage 1 signals
	logic [SAMPLE_W-1:0]      m;
	logic [P_W-1:0]           p;
	logic [P_W-SPAN_SH-1:0]   idx_full;
	logic [IDX_W-1:0]         idx_s1;
	logic [SPAN_SH-1:0]       fr_s1;
	logic                     sat_s1;

	// stage 2 signals
	logic [ROMA_W-1:0]        addr_lo;
	logic [ONE_W-1:0]         lo;
	logic [ONE_W-1:0]         hi;
	logic [ONE_W-1:0]         lo_s2;
	logic [ONE_W-1:0]         d_s2;
	logic [SPAN_SH-1:0]       fr_s2;
	logic                     sat_s2;

	// stage 3 signals
	logic [ONE_W+SPAN_SH-1:0] prod;
	logic [ONE_W:0]           y;

	// Split magnitude into table index and fraction of one table step
	always_comb begin
		m        = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;
		p        = P_W'(m) * P_W'(TANH_ENTRIES);
		idx_full = p[P_W-1:SPAN_SH];
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_full[IDX_W-1:0];
		fr_s1  <= p[SPAN_SH-1:0];
		sat_s1 <= (idx_full >= (P_W-SPAN_SH)'(TANH_ENTRIES));
	end

	// Read both neighboring table points
	always_comb begin
		addr_lo = ROMA_W'(idx_s1);
		lo      = TANH_ROM[addr_lo];
		hi      = TANH_ROM[addr_lo + ROMA_W'(1)];
	end

	always_ff @(posedge clk) begin
		lo_s2  <= lo;
		d_s2   <= (hi >= lo) ? (hi - lo) : '0;
		fr_s2  <= fr_s1;
		sat_s2 <= sat_s1;
	end

	// Interpolate, clamp to one beyond the table
	always_comb begin
		prod = (ONE_W+SPAN_SH)'(d_s2) * (ONE_W+SPAN_SH)'(fr_s2);
		y    = (ONE_W+1)'(lo_s2) + (ONE_W+1)'(prod >> SPAN_SH);
	end

	always_ff @(posedge clk) begin
		mag_s3 <= sat_s2 ? ONE_MAG : y[ONE_W-1:0];
	end

endmodule
`default_nettype wire

// ----- design/activation_relu_tanh_unit_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// activation_relu_tanh_unit_core: elementwise relu / tanh / linear activation
// Forward or derivative of the selected function on signed Q4.11 samples.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------
//   input    | start, busy          | sample, last_in
//   result   | done (one cycle)     | activated, last_out
//   config   | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// One word enters every cycle; busy stays low. Each result appears on done
// after its word passes the four pipeline stages (index split, table read,
// interpolation, square and select). Reset clears the stage valid bits and
// both mode registers. The result side has no back-pressure, so the
// pipeline never stalls.
// ----------------------------------------------------------------------------
module activation_relu_tanh_unit_core import art_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output      logic                       busy,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic                       last_in,
	output      logic                       done,
	output      logic signed [SAMPLE_W-1:0] activated,
	output      logic                       last_out,
	input  wire logic                       cfg_valid,
	output      logic                       cfg_ready,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [1:0]                 cfg_data
);

	act_mode_t                  act_mode_q;
	logic                       deriv_q;

	logic                       valid_s1;
	logic                       valid_s2;
	logic                       valid_s3;
	logic                       valid_s4;
	side_t                      side_s1;
	side_t                      side_s2;
	side_t                      side_s3;
	logic        [ONE_W-1:0]    mag_s3;

	logic        [2*ONE_W-1:0]  sq;
	logic signed [SAMPLE_W-1:0] tanh_val;
	logic signed [SAMPLE_W-1:0] dtanh_val;
	logic signed [SAMPLE_W-1:0] result;
	logic signed [SAMPLE_W-1:0] activated_s4;
	logic                       last_s4;

	// Always able to take a word on either channel
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Write mode registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_mode_q <= ACT_RELU;
			deriv_q    <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ACT_MODE:   act_mode_q <= act_mode_t'(cfg_data);
				CFG_DERIV_MODE: deriv_q    <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Carry sample and last flag beside the tanh datapath
	always_ff @(posedge clk) begin
		side_s1 <= '{last: last_in, x: sample};
		side_s2 <= side_s1;
		side_s3 <= side_s2;
	end

	art_tanh_mag u_tanh (
		.clk    (clk),
		.sample (sample),
		.mag_s3 (mag_s3)
	);

	// Sign the tanh value, form one minus t squared, select the result
	always_comb begin
		sq        = (2*ONE_W)'(mag_s3) * (2*ONE_W)'(mag_s3);
		tanh_val  = side_s3.x[SAMPLE_W-1] ? -SAMPLE_W'(mag_s3) : SAMPLE_W'(mag_s3);
		dtanh_val = ONE_Q - SAMPLE_W'(sq >> FRAC_BITS);
		result    = side_s3.x;
		if (!deriv_q) begin
			case (act_mode_q)
				ACT_RELU:   result = (side_s3.x > 0) ? side_s3.x : '0;
				ACT_TANH:   result = tanh_val;
				default:    result = side_s3.x;
			endcase
		end else begin
			case (act_mode_q)
				ACT_RELU:   result = (side_s3.x > 0) ? ONE_Q : '0;
				ACT_TANH:   result = dtanh_val;
				default:    result = ONE_Q;
			endcase
		end
	end

	// Hold the result word for its one strobe cycle
	always_ff @(posedge clk) begin
		activated_s4 <= result;
		last_s4      <= side_s3.last;
	end

	assign done      = valid_s4;
	assign activated = activated_s4;
	assign last_out  = last_s4;

endmodule
`default_nettype wire

// ----- design/art_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// art_checker: port-level checks for the activation unit
// Result timing against accepted words, no stalls, and last flag carried with its word.
// ----------------------------------------------------------------------------
module art_checker import art_pkg::*; (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       start,
	input wire logic                       busy,
	input wire logic                       last_in,
	input wire logic                       done,
	input wire logic                       last_out
);

	// The unit never pushes back on input words
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// Every accepted word yields a result on done
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("result missing four cycles after accept");

	// No result without a matching accepted word
	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result without a matching input word");

	// Last flag leaves with its own word
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (last_out == $past(last_in, 4)))
		else $error("last flag mismatch");

endmodule

bind activation_relu_tanh_unit_core art_checker u_art_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.last_in  (last_in),
	.done     (done),
	.last_out (last_out)
);
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for activation_relu_tanh_unit_core
// Drives Q4.11 words through every mode setting, predicts each relu / tanh /
// linear result and its derivative in a scoreboard, and compares every done
// strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import art_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int WORD_COUNT   = 1100;

	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic                       last;
	} act_word_t;

	// Scoreboard: own copy of the mode registers and the tanh table
	class activation_scoreboard;
		int          tanh_points [0:TANH_ENTRIES];
		act_mode_t   func_sel;
		logic        deriv_sel;
		act_word_t   expected_words [$];
		int          errors;

		function new();
			int i;
			for (i = 0; i <= TANH_ENTRIES; i++) begin
				tanh_points[i] = table_point(i);
			end
			func_sel  = ACT_RELU;
			deriv_sel = 1'b0;
			errors    = 0;
		endfunction

		// tanh(4*i/N) from e^(-8i/N), computed with Q30 integers
		function int table_point(int i);
			logic [63:0] z;
			logic [63:0] e;
			logic [63:0] term;
			logic [63:0] u;
			logic [63:0] num;
			logic [63:0] den;
			logic [63:0] q30;
			int k;
			q30  = 64'd1 << 30;
			z    = (64'(i) << 29) / 64'(TANH_ENTRIES);
			e    = q30;
			term = q30;
			for (k = 1; k <= 24; k++) begin
				term = ((term * z) >> 30) / 64'(k);
				e    = e + term;
			end
			u = (64'd1 << 60) / e;
			for (k = 0; k < 4; k++) begin
				u = (u * u) >> 30;
			end
			if (u > q30) begin
				u = q30;
			end
			num = q30 - u;
			den = q30 + u;
			return int'(((num << (FRAC_BITS + 1)) + den) / (den * 2));
		endfunction

		// Interpolated odd tanh, saturating to one past the table
		function int tanh_of(int x);
			int mag;
			int p;
			int idx;
			int fr;
			int lo;
			int hi;
			int y;
			mag = (x < 0) ? -x : x;
			p   = mag * TANH_ENTRIES;
			idx = p >> (FRAC_BITS + 2);
			fr  = p % (4 << FRAC_BITS);
			if (idx >= TANH_ENTRIES) begin
				y = 1 << FRAC_BITS;
			end else begin
				lo = tanh_points[idx];
				hi = tanh_points[idx + 1];
				y  = lo + (((hi >= lo) ? hi - lo : 0) * fr) / (4 << FRAC_BITS);
			end
			return (x < 0) ? -y : y;
		endfunction

		function logic signed [SAMPLE_W-1:0] activation_of(logic signed [SAMPLE_W-1:0] x);
			int xi;
			int t;
			int r;
			int one;
			xi  = x;
			one = 1 << FRAC_BITS;
			if (!deriv_sel) begin
				case (func_sel)
					ACT_RELU: r = (xi > 0) ? xi : 0;
					ACT_TANH: r = tanh_of(xi);
					default:  r = xi;
				endcase
			end else begin
				case (func_sel)
					ACT_RELU: r = (xi > 0) ? one : 0;
					ACT_TANH: begin
						t = tanh_of(xi);
						if (t < 0) begin
							t = -t;
						end
						r = one - ((t * t) >> FRAC_BITS);
					end
					default:  r = one;
				endcase
			end
			return SAMPLE_W'(r);
		endfunction

		// Mirror a register write; unknown indexes are dropped
		function void write_reg(logic [1:0] idx, logic [1:0] data);
			if (idx == CFG_ACT_MODE) begin
				func_sel = act_mode_t'(data);
			end else if (idx == CFG_DERIV_MODE) begin
				deriv_sel = data[0];
			end
		endfunction

		function void note_word(logic signed [SAMPLE_W-1:0] x, logic last);
			act_word_t w;
			w.value = activation_of(x);
			w.last  = last;
			expected_words.push_back(w);
		endfunction

		function void check_result(logic signed [SAMPLE_W-1:0] value, logic last);
			act_word_t w;
			if (expected_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual %0d last %0b",
					$time, value, last);
				return;
			end
			w = expected_words.pop_front();
			if (value !== w.value) begin
				errors++;
				$display("%0t: activated mismatch: expected %0d, actual %0d",
					$time, w.value, value);
			end
			if (last !== w.last) begin
				errors++;
				$display("%0t: last_out mismatch: expected %0b, actual %0b",
					$time, w.last, last);
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_in;
	logic                       done;
	logic signed [SAMPLE_W-1:0] activated;
	logic                       last_out;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [1:0]                 cfg_index;
	logic [1:0]                 cfg_data;

	activation_scoreboard sb;
	int cycle_count;

	activation_relu_tanh_unit_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample    (sample),
		.last_in   (last_in),
		.done      (done),
		.activated (activated),
		.last_out  (last_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock: 2 ns period
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Check every result word on its strobe
	always @(posedge clk) begin
		if (arst_n && done && sb != null) begin
			sb.check_result(activated, last_out);
		end
	end

	// Abort a hung run
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Hold until every predicted word has come back
	task automatic wait_drain();
		while (sb.pending() != 0) begin
			@(negedge clk);
		end
	endtask

	// Write one mode register once the pipeline is empty
	task automatic write_cfg(logic [1:0] idx, logic [1:0] data);
		start = 1'b0;
		wait_drain();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_index = 2'($urandom());
		cfg_data  = 2'($urandom());
	endtask

	task automatic set_mode(act_mode_t func, logic [1:0] deriv);
		write_cfg(CFG_ACT_MODE, func);
		write_cfg(CFG_DERIV_MODE, deriv);
	endtask

	// Offer one word and hold it until taken
	task automatic send_word(logic signed [SAMPLE_W-1:0] x, logic last);
		start   = 1'b1;
		sample  = x;
		last_in = last;
		do begin
			@(posedge clk);
		end while (busy);
		sb.note_word(x, last);
		@(negedge clk);
	endtask

	// Drop start for idle cycles with junk on the data lines; each cycle idles
	// with the given percentage
	task automatic maybe_idle(int pct);
		while ($urandom_range(1, 100) <= pct) begin
			start   = 1'b0;
			sample  = SAMPLE_W'($urandom());
			last_in = 1'($urandom());
			@(negedge clk);
		end
	endtask

	// Bias values toward the tanh table, its edges and the extremes
	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom_range(0, 16383) - 8192;
			4:          v = ($urandom_range(0, 1) ? 1 : -1) * (8190 + $urandom_range(0, 4));
			5:          v = $urandom_range(0, 64) - 32;
			6: begin
				case ($urandom_range(0, 3))
					0:       v = -32768;
					1:       v = 32767;
					2:       v = -32767;
					default: v = 32766;
				endcase
			end
			default:    v = $urandom();
		endcase
		return SAMPLE_W'(v);
	endfunction

	initial begin
		logic signed [SAMPLE_W-1:0] corners [0:11];
		int k;
		int s;
		int n;
		int j;
		int sent;
		int seg_len;
		int pct;
		act_mode_t func;

		corners = '{-32768, 32767, 0, 1, -1, 2048, -2048, 8191, 8192, -8191, -8193, 1000};

		sb        = new();
		arst_n    = 1'b0;
		start     = 1'b0;
		sample    = '0;
		last_in   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: every mode setting, corner values, ignored register slots
		write_cfg(2'd2, 2'd3);
		write_cfg(2'd3, 2'd1);
		k = 0;
		for (s = 0; s < 8; s++) begin
			func = act_mode_t'(s[1:0]);
			set_mode(func, (s == 5) ? 2'b11 : (s == 1 ? 2'b10 : {1'b0, s[2]}));
			n = (func == ACT_TANH) ? 8 : 1;
			for (j = 0; j < n; j++) begin
				send_word(corners[k % 12], (k % 3) == 2);
				k++;
			end
		end

		// Random: segments under random modes, three idling phases
		sent = 0;
		while (sent < WORD_COUNT) begin
			pct = (sent < WORD_COUNT / 3) ? 34 : (sent < 2 * WORD_COUNT / 3) ? 86 : 0;
			if ($urandom_range(0, 3) == 0) begin
				func = $urandom_range(0, 1) ? ACT_RELU : ACT_NONE;
			end else begin
				func = act_mode_t'($urandom_range(0, 3));
			end
			set_mode(func, 2'($urandom_range(0, 3)));
			if ($urandom_range(0, 7) == 0) begin
				write_cfg(2'($urandom_range(2, 3)), 2'($urandom()));
			end
			seg_len = $urandom_range(10, 60);
			for (j = 0; j < seg_len && sent < WORD_COUNT; j++) begin
				send_word(random_sample(), $urandom_range(0, 7) == 0);
				sent++;
				if ($urandom_range(0, 99) == 0) begin
					start = 1'b0;
					wait_drain();
				end else begin
					maybe_idle(pct);
				end
			end
		end

		// Drain, then watch a while for stray strobes
		start = 1'b0;
		wait_drain();
		repeat (12) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- activation_relu_tanh_unit_core.f -----
design/art_pkg.sv
design/art_tanh_mag.sv
design/activation_relu_tanh_unit_core.sv
design/art_checker.sv
bench/testbench.sv
